>>> src/hcd_pkg.sv
// Shared types and constants for the HTTP chunked-transfer decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package hcd_pkg;

    // Default width of the chunk size counter
    localparam int SIZE_BITS_DEF = 32;

    // Depth of the queue between front and back (power of two, at least 2)
    localparam int QUEUE_DEPTH = 2;

    // Byte codes of interest
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    // Classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;     // raw byte
        logic       is_lf;
        logic       is_cr;
        logic       is_hex;
        logic [3:0] hex_val;  // digit value, meaningful when is_hex
    } item_t;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_DATA    = 3'd1,
        PH_SKIP1   = 3'd2,
        PH_SKIP2   = 3'd3,
        PH_TRAILER = 3'd4
    } phase_t;

endpackage : hcd_pkg

`default_nettype wire

>>> src/http_chunked_decoder_core.sv
// Top level of the HTTP chunked-transfer decoder: front classifier, queue, back end.
// Depends on hcd_pkg, hcd_front, hcd_queue and hcd_back.
//
//  channel | dir | tdata            | tuser
//  --------+-----+------------------+------------------------------------
//  s_*     | in  | in_byte [7:0]    | -
//  m_*     | out | out_byte [7:0]   | message_done [0], size_error [1]
//
// One byte per clock is sustained while the output is not stalled; an accepted
// byte is written to the queue, and bytes that yield a result then pass on to the output register.
// The back end takes one queued byte per cycle; only bytes that yield a
// result wait for the output register to be free.
// Reset (rst_n low, asynchronous) empties the queue and output and rearms
// the decoder for a new message.
`default_nettype none

module http_chunked_decoder_core #(
    parameter int SIZE_BITS = hcd_pkg::SIZE_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [1:0]      m_tuser    // [0] message_done, [1] size_error
);
    import hcd_pkg::*;

    item_t  front_item;
    item_t  q_item;
    logic   q_valid;
    logic   q_ready;

    hcd_front u_front (
        .in_byte (s_tdata),
        .item    (front_item)
    );

    hcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_item  (front_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    hcd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule : http_chunked_decoder_core

`default_nettype wire

>>> src/hcd_front.sv
// Front end: classifies each incoming byte (LF, CR, hex digit and its value).
// Depends on hcd_pkg.
`default_nettype none

module hcd_front (
    input  wire logic [7:0]     in_byte,
    output hcd_pkg::item_t      item
);
    import hcd_pkg::*;

    logic is_dec;
    logic is_lower;
    logic is_upper;

    // hex digit ranges
    always_comb
    begin
        is_dec   = (in_byte >= 8'h30) && (in_byte <= 8'h39);
        is_lower = (in_byte >= 8'h61) && (in_byte <= 8'h66);
        is_upper = (in_byte >= 8'h41) && (in_byte <= 8'h46);
    end

    // build the classified item
    always_comb
    begin
        item.data   = in_byte;
        item.is_lf  = (in_byte == BYTE_LF);
        item.is_cr  = (in_byte == BYTE_CR);
        item.is_hex = is_dec || is_lower || is_upper;
        // letters: low nibble 1..6 maps to 10..15
        item.hex_val = is_dec ? in_byte[3:0] : (in_byte[3:0] + 4'd9);
    end

endmodule : hcd_front

`default_nettype wire

>>> src/hcd_queue.sv
// Short first-in first-out queue of classified bytes between front and back.
// Depends on hcd_pkg.
`default_nettype none

module hcd_queue #(
    parameter int DEPTH = hcd_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire hcd_pkg::item_t wr_item,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output hcd_pkg::item_t      rd_item
);
    import hcd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t           slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_wr;
    logic            do_rd;

    // handshake
    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_item  = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule : hcd_queue

`default_nettype wire

>>> src/hcd_back.sv
// Back end: chunk state machine, size counter and registered result output.
// Depends on hcd_pkg.
`default_nettype none

module hcd_back #(
    parameter int SIZE_BITS = hcd_pkg::SIZE_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire hcd_pkg::item_t q_item,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,
    output logic [1:0]          m_tuser
);
    import hcd_pkg::*;

    phase_t                phase_reg,       phase_next;
    logic [SIZE_BITS-1:0]  bytes_left_reg,  bytes_left_next;
    logic                  size_ended_reg,  size_ended_next;
    logic                  overflow_reg,    overflow_next;
    logic                  line_empty_reg,  line_empty_next;

    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_done_reg;
    logic                  out_err_reg;

    logic                  left_zero;
    logic                  left_one;
    logic                  emit;
    logic                  emit_done;
    logic                  out_free;
    logic                  fire;

    assign left_zero = (bytes_left_reg == '0);
    assign left_one  = (bytes_left_reg == SIZE_BITS'(1));

    // does the head request produce a result
    always_comb
    begin
        emit_done = (phase_reg == PH_SIZE) && q_item.is_lf && left_zero;
        emit      = (phase_reg == PH_DATA) || emit_done;
    end

    // take a request when the output slot is free or it yields nothing
    assign out_free = !out_valid_reg || m_tready;
    assign q_ready  = out_free || !emit;
    assign fire     = q_valid && q_ready;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            unique case (phase_reg)
                PH_SIZE:
                begin
                    if (q_item.is_lf)
                    begin
                        phase_next = left_zero ? PH_TRAILER : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (left_one)
                    begin
                        phase_next = PH_SKIP1;
                    end
                end
                PH_SKIP1:   phase_next = PH_SKIP2;
                PH_SKIP2:   phase_next = PH_SIZE;
                PH_TRAILER:
                begin
                    if (q_item.is_lf && line_empty_reg)
                    begin
                        phase_next = PH_SIZE;
                    end
                end
                default:    phase_next = PH_SIZE;
            endcase
        end
    end

    // counter and flags
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        size_ended_next = size_ended_reg;
        overflow_next   = overflow_reg;
        line_empty_next = line_empty_reg;
        if (fire)
        begin
            unique case (phase_reg)
                PH_SIZE:
                begin
                    if (q_item.is_lf)
                    begin
                        if (left_zero)
                        begin
                            line_empty_next = 1'b1;
                        end
                    end
                    else if (!size_ended_reg)
                    begin
                        if (!q_item.is_hex)
                        begin
                            size_ended_next = 1'b1;
                        end
                        // a non-zero top nibble means the shift would overflow
                        else if (bytes_left_reg[SIZE_BITS-1 -: 4] != 4'd0)
                        begin
                            bytes_left_next = '1;
                            overflow_next   = 1'b1;
                        end
                        else
                        begin
                            bytes_left_next = {bytes_left_reg[SIZE_BITS-5:0],
                                               q_item.hex_val};
                        end
                    end
                end
                PH_DATA:
                begin
                    bytes_left_next = bytes_left_reg - SIZE_BITS'(1);
                end
                PH_SKIP1:
                begin
                    bytes_left_next = bytes_left_reg;
                end
                PH_SKIP2:
                begin
                    bytes_left_next = '0;
                    size_ended_next = 1'b0;
                end
                PH_TRAILER:
                begin
                    if (q_item.is_lf)
                    begin
                        if (line_empty_reg)
                        begin
                            bytes_left_next = '0;
                            size_ended_next = 1'b0;
                            overflow_next   = 1'b0;
                        end
                        line_empty_next = 1'b1;
                    end
                    else if (!q_item.is_cr)
                    begin
                        line_empty_next = 1'b0;
                    end
                end
                default:
                begin
                    bytes_left_next = '0;
                    size_ended_next = 1'b0;
                    overflow_next   = 1'b0;
                    line_empty_next = 1'b1;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIZE;
            bytes_left_reg <= '0;
            size_ended_reg <= 1'b0;
            overflow_reg   <= 1'b0;
            line_empty_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            size_ended_reg <= size_ended_next;
            overflow_reg   <= overflow_next;
            line_empty_reg <= line_empty_next;
            if (fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_byte_reg <= emit_done ? 8'h00 : q_item.data;
            out_done_reg <= emit_done;
            out_err_reg  <= overflow_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_err_reg, out_done_reg};

endmodule : hcd_back

`default_nettype wire
